// ===== sv/lcdt_pkg.sv =====
package lcdt_pkg;

    // Mode register, one-hot.
    typedef enum logic [3:0] {
        ST_HBLANK   = 4'b0001,
        ST_VBLANK   = 4'b0010,
        ST_OAM      = 4'b0100,
        ST_TRANSFER = 4'b1000
    } t_mode;

    // Mode codes as they appear on the mode field and in STAT.
    localparam logic [1:0] MC_HBLANK   = 2'd0;
    localparam logic [1:0] MC_VBLANK   = 2'd1;
    localparam logic [1:0] MC_OAM      = 2'd2;
    localparam logic [1:0] MC_TRANSFER = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_LCD_ENABLE   = 2'd0;
    localparam logic [1:0] REG_STAT_ENABLES = 2'd1;
    localparam logic [1:0] REG_LYC_VALUE    = 2'd2;

    localparam int         VBLANK_LINES     = 10;
    localparam logic [7:0] STAT_TOP_BIT     = 8'h80;
    localparam logic [7:0] STAT_ENABLE_MASK = 8'h78;

    // STAT source enable bits.
    localparam int SRC_HBLANK = 0;
    localparam int SRC_VBLANK = 1;
    localparam int SRC_OAM    = 2;
    localparam int SRC_LYC    = 3;

    typedef struct packed {
        logic       lcd_enable;
        logic [3:0] stat_enables;
        logic [7:0] lyc_value;
    } t_cfg;

    typedef struct packed {
        t_mode      mode;
        logic [7:0] line;
        logic [3:0] vbl_done;
        logic [2:0] stat_latched;
        logic       stat_cond;
    } t_ctl;

    typedef struct packed {
        logic stat_irq;
        logic vblank_irq;
        logic frame_start;
        logic render_line;
    } t_flags;

    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] c;
        case (m)
            ST_HBLANK:   c = MC_HBLANK;
            ST_VBLANK:   c = MC_VBLANK;
            ST_OAM:      c = MC_OAM;
            default:     c = MC_TRANSFER;
        endcase
        return c;
    endfunction

endpackage

// ===== sv/lcdt_in_if.sv =====
interface lcdt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] delta_ticks;

    modport source (output valid, output delta_ticks, input ready);
    modport sink   (input valid, input delta_ticks, output ready);
endinterface

// ===== sv/lcdt_out_if.sv =====
interface lcdt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] line;
    logic [7:0] stat_value;
    logic       stat_irq;
    logic       vblank_irq;
    logic       frame_start;
    logic       render_line;

    modport source (
        output valid, output mode, output line, output stat_value, output stat_irq,
        output vblank_irq, output frame_start, output render_line, input ready
    );
    modport sink (
        input valid, input mode, input line, input stat_value, input stat_irq,
        input vblank_irq, input frame_start, input render_line, output ready
    );
endinterface

// ===== sv/lcdt_step.sv =====
module lcdt_step
    import lcdt_pkg::*;
#(
    parameter int OAM_TICKS      = 80,
    parameter int TRANSFER_TICKS = 172,
    parameter int HBLANK_TICKS   = 204,
    parameter int VISIBLE_LINES  = 144,
    parameter int TIMER_W        = 13
) (
    input  logic [7:0]         i_delta,
    input  logic [TIMER_W-1:0] i_timer,
    input  t_ctl               i_ctl,
    input  t_cfg               i_cfg,
    output logic [TIMER_W-1:0] o_timer,
    output t_ctl               o_ctl,
    output t_flags             o_flags
);

    localparam int LINE_TICKS = OAM_TICKS + TRANSFER_TICKS + HBLANK_TICKS;

    logic [TIMER_W-1:0]      timer_sum;
    logic [TIMER_W-1:0]      mode_len;
    logic [VBLANK_LINES-1:0] line_ge;
    logic [3:0]              vbl_lines;
    logic [7:0]              line_mid;
    logic [3:0]              done_mid;
    logic                    mode_end;
    t_mode                   next_mode;
    logic [7:0]              next_line;
    logic                    coinc;
    logic [1:0]              mbits;
    logic                    cond;

    assign timer_sum = i_timer + TIMER_W'(i_delta);

    // Lines elapsed in VBlank: one constant compare per possible line step.
    always_comb begin
        for (int k = 1; k <= VBLANK_LINES; k++) begin
            line_ge[k-1] = (timer_sum >= TIMER_W'(k * LINE_TICKS));
        end
        vbl_lines = 4'($countones(line_ge));
    end

    always_comb begin
        if (i_ctl.mode == ST_VBLANK) begin
            line_mid = i_ctl.line + 8'(vbl_lines - i_ctl.vbl_done);
            done_mid = vbl_lines;
        end else begin
            line_mid = i_ctl.line;
            done_mid = i_ctl.vbl_done;
        end
    end

    always_comb begin
        case (i_ctl.mode)
            ST_HBLANK: mode_len = TIMER_W'(HBLANK_TICKS);
            ST_VBLANK: mode_len = TIMER_W'(VBLANK_LINES * LINE_TICKS);
            ST_OAM:    mode_len = TIMER_W'(OAM_TICKS);
            default:   mode_len = TIMER_W'(TRANSFER_TICKS);
        endcase
    end

    assign mode_end = (timer_sum >= mode_len);

    always_comb begin
        next_mode           = i_ctl.mode;
        next_line           = line_mid;
        o_ctl               = i_ctl;
        o_ctl.vbl_done      = done_mid;
        o_flags             = '0;
        o_timer             = timer_sum;
        coinc               = 1'b0;
        mbits               = MC_HBLANK;
        cond                = 1'b0;
        if (mode_end) begin
            case (i_ctl.mode)
                ST_HBLANK: begin
                    next_line = line_mid + 8'd1;
                    if (next_line == 8'(VISIBLE_LINES)) begin
                        next_mode           = ST_VBLANK;
                        o_ctl.vbl_done      = 4'd0;
                        o_flags.frame_start = 1'b1;
                        o_flags.vblank_irq  = i_cfg.lcd_enable;
                    end else begin
                        next_mode = ST_OAM;
                    end
                end
                ST_VBLANK: begin
                    next_line      = 8'd0;
                    o_ctl.vbl_done = 4'd0;
                    next_mode      = ST_OAM;
                end
                ST_OAM: begin
                    next_mode = ST_TRANSFER;
                end
                default: begin
                    o_flags.render_line = i_cfg.lcd_enable;
                    next_mode           = ST_HBLANK;
                end
            endcase
            o_timer = '0;

            // STAT is rebuilt only on a mode change.
            coinc = (next_line == i_cfg.lyc_value);
            mbits = i_cfg.lcd_enable ? mode_code(next_mode) : MC_HBLANK;
            if (i_cfg.lcd_enable) begin
                cond = (i_cfg.stat_enables[SRC_LYC] && coinc)
                    || (i_cfg.stat_enables[SRC_HBLANK] && mbits == MC_HBLANK)
                    || (i_cfg.stat_enables[SRC_OAM] && mbits == MC_OAM)
                    || ((i_cfg.stat_enables[SRC_VBLANK] || i_cfg.stat_enables[SRC_OAM])
                        && mbits == MC_VBLANK);
            end
            o_ctl.stat_latched = {coinc, mbits};
            o_ctl.stat_cond    = cond;
            o_flags.stat_irq   = cond && !i_ctl.stat_cond;
        end
        o_ctl.mode = next_mode;
        o_ctl.line = next_line;
    end

endmodule

// ===== sv/lcd_mode_timing_and_stat_irq.sv =====
// LCD mode timing and STAT interrupt generator.
//
// Input channel i_in carries one tick delta per request; output channel o_out
// returns one result per request: current mode, line counter LY, STAT byte and
// the pulses stat_irq, vblank_irq, frame_start and render_line.
// Configuration (LCD enable, STAT enables, LYC) is written on i_cfg_we/idx/data
// by the user only while no request is in flight; not enforced by the block.
//
// An accepted request passes the input register, then the mode step logic
// feeding the result register. Throughput is one request per cycle unless the
// receiver stalls; the mode, timer and line registers are updated once per
// request in the step stage, so each unstalled cycle can carry a new delta.
// When the receiver stalls, the result register holds and the input register
// still takes one more request; i_in.ready falls once both are full.
// Reset (synchronous, active low) clears the configuration, puts the mode in
// OAM scan at line 0 with a zero timer and empties both pipeline registers.
module lcd_mode_timing_and_stat_irq
    import lcdt_pkg::*;
#(
    parameter int OAM_TICKS      = 80,
    parameter int TRANSFER_TICKS = 172,
    parameter int HBLANK_TICKS   = 204,
    parameter int VISIBLE_LINES  = 144
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lcdt_in_if.sink       i_in,
    lcdt_out_if.source    o_out,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);

    localparam int LINE_TICKS = OAM_TICKS + TRANSFER_TICKS + HBLANK_TICKS;
    localparam int TIMER_W    = $clog2(VBLANK_LINES * LINE_TICKS + 256);

    t_cfg               r_cfg;
    logic               r_s1_valid;
    logic [7:0]         r_s1_delta;
    logic [TIMER_W-1:0] r_timer;
    t_ctl               r_ctl;
    logic               r_o_valid;
    logic [1:0]         r_o_mode;
    logic [7:0]         r_o_line;
    logic [7:0]         r_o_stat;
    t_flags             r_o_flags;

    logic [TIMER_W-1:0] n_timer;
    t_ctl               n_ctl;
    t_flags             n_flags;
    logic               s1_adv;
    logic               in_acc;

    assign s1_adv      = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_adv;
    assign in_acc      = i_in.valid && i_in.ready;

    lcdt_step #(
        .OAM_TICKS      (OAM_TICKS),
        .TRANSFER_TICKS (TRANSFER_TICKS),
        .HBLANK_TICKS   (HBLANK_TICKS),
        .VISIBLE_LINES  (VISIBLE_LINES),
        .TIMER_W        (TIMER_W)
    ) u_step (
        .i_delta (r_s1_delta),
        .i_timer (r_timer),
        .i_ctl   (r_ctl),
        .i_cfg   (r_cfg),
        .o_timer (n_timer),
        .o_ctl   (n_ctl),
        .o_flags (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LCD_ENABLE:   r_cfg.lcd_enable   <= i_cfg_data[0];
                REG_STAT_ENABLES: r_cfg.stat_enables <= i_cfg_data[3:0];
                REG_LYC_VALUE:    r_cfg.lyc_value    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
        if (in_acc) begin
            r_s1_delta <= i_in.delta_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_ctl   <= '{mode: ST_OAM, line: 8'd0, vbl_done: 4'd0,
                         stat_latched: 3'd0, stat_cond: 1'b0};
        end else if (s1_adv) begin
            r_timer <= n_timer;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_o_flags <= '0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
            r_o_flags <= n_flags;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
        if (s1_adv) begin
            r_o_mode <= mode_code(n_ctl.mode);
            r_o_line <= n_ctl.line;
            r_o_stat <= STAT_TOP_BIT | ({1'b0, r_cfg.stat_enables, 3'b000} & STAT_ENABLE_MASK)
                      | {5'b00000, n_ctl.stat_latched};
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.mode        = r_o_mode;
    assign o_out.line        = r_o_line;
    assign o_out.stat_value  = r_o_stat;
    assign o_out.stat_irq    = r_o_flags.stat_irq;
    assign o_out.vblank_irq  = r_o_flags.vblank_irq;
    assign o_out.frame_start = r_o_flags.frame_start;
    assign o_out.render_line = r_o_flags.render_line;

    a_frame_start_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_flags.frame_start) |->
            (r_o_mode == MC_VBLANK && r_o_line == 8'(VISIBLE_LINES)))
        else $error("frame_start without entry into VBlank at the last visible line");

    a_render_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_flags.render_line) |-> (r_o_mode == MC_HBLANK))
        else $error("render_line outside the transfer to HBlank change");

    a_vblank_irq_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_flags.vblank_irq |-> r_o_flags.frame_start)
        else $error("vblank_irq without frame_start");

    a_vbl_done_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.mode != ST_VBLANK) |-> (r_ctl.vbl_done == 4'd0))
        else $error("VBlank line count left set outside VBlank");

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lcdt_pkg::*;

    localparam int OAM_LEN     = 80;
    localparam int XFER_LEN    = 172;
    localparam int HBLANK_LEN  = 204;
    localparam int VISIBLE     = 144;
    localparam int LINE_LEN    = OAM_LEN + XFER_LEN + HBLANK_LEN;
    localparam int LATENCY     = 2;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 225;

    // Register index past the end of the register map; writes to it are dropped.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] line;
        logic [7:0] stat_value;
        logic       stat_irq;
        logic       vblank_irq;
        logic       frame_start;
        logic       render_line;
    } t_lcd_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;
    bit         calm;

    lcdt_in_if  in_if ();
    lcdt_out_if out_if ();

    lcd_mode_timing_and_stat_irq #(
        .OAM_TICKS      (OAM_LEN),
        .TRANSFER_TICKS (XFER_LEN),
        .HBLANK_TICKS   (HBLANK_LEN),
        .VISIBLE_LINES  (VISIBLE)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the configuration registers.
    logic       cfg_lcd_on;
    logic [3:0] cfg_stat_en;
    logic [7:0] cfg_lyc;

    // Shadow of the mode sequencer.
    logic [1:0] lcd_mode;
    int         lcd_timer;
    logic [7:0] lcd_line;
    int         vbl_lines;
    logic [2:0] stat_bits;
    logic       stat_cond;

    t_lcd_result pending_results[$];
    int          mismatch_count;
    int          results_checked;

    function automatic t_lcd_result step_lcd_timing(input logic [7:0] delta);
        t_lcd_result r;
        int          lines;
        int          mode_len;
        logic        coinc;
        logic [1:0]  mbits;
        logic        cond;
        logic [1:0]  nxt;

        r = '0;
        lcd_timer += delta;

        if (lcd_mode == MC_VBLANK) begin
            lines = lcd_timer / LINE_LEN;
            if (lines > VBLANK_LINES)
                lines = VBLANK_LINES;
            while (vbl_lines < lines) begin
                vbl_lines++;
                lcd_line++;
            end
        end

        case (lcd_mode)
            MC_HBLANK: mode_len = HBLANK_LEN;
            MC_VBLANK: mode_len = LINE_LEN * VBLANK_LINES;
            MC_OAM:    mode_len = OAM_LEN;
            default:   mode_len = XFER_LEN;
        endcase

        if (lcd_timer >= mode_len) begin
            case (lcd_mode)
                MC_HBLANK: begin
                    lcd_line++;
                    if (lcd_line == VISIBLE) begin
                        nxt = MC_VBLANK;
                        vbl_lines = 0;
                        r.frame_start = 1'b1;
                        r.vblank_irq = cfg_lcd_on;
                    end else begin
                        nxt = MC_OAM;
                    end
                end
                MC_VBLANK: begin
                    lcd_line = 8'd0;
                    vbl_lines = 0;
                    nxt = MC_OAM;
                end
                MC_OAM: nxt = MC_TRANSFER;
                default: begin
                    r.render_line = cfg_lcd_on;
                    nxt = MC_HBLANK;
                end
            endcase
            lcd_mode = nxt;
            lcd_timer = 0;

            // STAT is only rebuilt here, on a mode change.
            coinc = (lcd_line == cfg_lyc);
            mbits = cfg_lcd_on ? lcd_mode : MC_HBLANK;
            stat_bits = {coinc, mbits};
            cond = cfg_lcd_on &&
                   ((cfg_stat_en[SRC_LYC] && coinc) ||
                    (cfg_stat_en[SRC_HBLANK] && mbits == MC_HBLANK) ||
                    (cfg_stat_en[SRC_OAM] && mbits == MC_OAM) ||
                    ((cfg_stat_en[SRC_VBLANK] || cfg_stat_en[SRC_OAM]) &&
                     mbits == MC_VBLANK));
            r.stat_irq = cond && !stat_cond;
            stat_cond = cond;
        end

        r.mode = lcd_mode;
        r.line = lcd_line;
        r.stat_value = STAT_TOP_BIT | ({1'b0, cfg_stat_en, 3'b000} & STAT_ENABLE_MASK) |
                       {5'b00000, stat_bits};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                 results_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_delta(input logic [7:0] delta);
        while (!calm && $urandom_range(99) < 38) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.delta_ticks <= delta;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        pending_results = {pending_results, step_lcd_timing(delta)};
    endtask

    task automatic pause_until_drained();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LCD_ENABLE:   cfg_lcd_on = data[0];
            REG_STAT_ENABLES: cfg_stat_en = data[3:0];
            REG_LYC_VALUE:    cfg_lyc = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic on, input logic [3:0] en, input logic [7:0] lyc);
        write_reg(REG_LCD_ENABLE, {7'b0000000, on});
        write_reg(REG_STAT_ENABLES, {4'b0000, en});
        write_reg(REG_LYC_VALUE, lyc);
    endtask

    // Walks the OAM, transfer and HBlank boundaries with the LCD off, just below and at each length.
    task automatic test_mode_walk();
        send_delta(8'd0);
        send_delta(8'd79);
        send_delta(8'd1);
        send_delta(8'd171);
        send_delta(8'd1);
        send_delta(8'd203);
        send_delta(8'd1);
        send_delta(8'd255);
        send_delta(8'd255);
        send_delta(8'd255);
    endtask

    // Register changes without a mode change must leave the latched STAT bits alone.
    task automatic test_stale_stat();
        pause_until_drained();
        set_config(1'b1, 4'hF, 8'd2);
        send_delta(8'd0);
        send_delta(8'd0);
        send_delta(8'd255);
        send_delta(8'd255);
        send_delta(8'd255);
        pause_until_drained();
        // Data wider than the register is truncated; the unused index is ignored.
        write_reg(REG_LCD_ENABLE, 8'hFE);
        write_reg(REG_STAT_ENABLES, 8'hA5);
        write_reg(REG_UNUSED, 8'hFF);
        write_reg(REG_LYC_VALUE, 8'hFF);
        send_delta(8'h55);
        send_delta(8'hAA);
        send_delta(8'hFF);
        send_delta(8'h00);
        send_delta(8'h01);
        pause_until_drained();
        write_reg(REG_LCD_ENABLE, 8'h01);
        send_delta(8'd255);
        send_delta(8'd255);
        send_delta(8'd255);
    endtask

    // Mostly large deltas so that the phases together cross VBlank and the line wrap.
    task automatic test_random_frames();
        logic [7:0] d;

        for (int p = 0; p < 8; p++) begin
            pause_until_drained();
            case (p)
                0: set_config(1'b1, 4'hF, 8'd0);
                1: set_config(1'b0, 4'hF, 8'd255);
                2: set_config(1'b1, 4'h0, 8'd153);
                3: set_config(1'b1, 4'h2, 8'd144);
                4: set_config(1'b1, 4'h4, 8'($urandom_range(153)));
                5: set_config(1'b1, 4'h8, 8'($urandom_range(153)));
                default: set_config(1'($urandom_range(1)), 4'($urandom_range(15)),
                                    8'($urandom_range(154)));
            endcase
            calm <= (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(99) < 80)
                    d = 8'($urandom_range(255, 100));
                else
                    d = 8'($urandom_range(255));
                send_delta(d);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_result
        t_lcd_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, mode", out_if.mode, 0);
            end else begin
                want = pending_results.pop_front();
                if (out_if.mode !== want.mode)
                    report_mismatch("mode", out_if.mode, want.mode);
                if (out_if.line !== want.line)
                    report_mismatch("line", out_if.line, want.line);
                if (out_if.stat_value !== want.stat_value)
                    report_mismatch("stat_value", out_if.stat_value, want.stat_value);
                if (out_if.stat_irq !== want.stat_irq)
                    report_mismatch("stat_irq", out_if.stat_irq, want.stat_irq);
                if (out_if.vblank_irq !== want.vblank_irq)
                    report_mismatch("vblank_irq", out_if.vblank_irq, want.vblank_irq);
                if (out_if.frame_start !== want.frame_start)
                    report_mismatch("frame_start", out_if.frame_start, want.frame_start);
                if (out_if.render_line !== want.render_line)
                    report_mismatch("render_line", out_if.render_line, want.render_line);
            end
            results_checked++;
        end
    end

    initial begin : result_ready
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= calm || ($urandom_range(99) >= 38);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        in_if.valid <= 1'b0;
        in_if.delta_ticks <= 8'd0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_LCD_ENABLE;
        i_cfg_data <= 8'd0;
        i_rst_n <= 1'b0;
        calm <= 1'b0;
        mismatch_count = 0;
        results_checked = 0;
        cfg_lcd_on = 1'b0;
        cfg_stat_en = 4'h0;
        cfg_lyc = 8'd0;
        lcd_mode = MC_OAM;
        lcd_timer = 0;
        lcd_line = 8'd0;
        vbl_lines = 0;
        stat_bits = 3'b000;
        stat_cond = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_mode_walk();
        test_stale_stat();
        test_random_frames();
        pause_until_drained();

        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lcdt_pkg.sv
sv/lcdt_in_if.sv
sv/lcdt_out_if.sv
sv/lcdt_step.sv
sv/lcd_mode_timing_and_stat_irq.sv
test/testbench.sv
